### hdl/unordered_tuple_hash_top_macros.svh
// Assertion macros for the unordered tuple hash block.
// Used by unordered_tuple_hash_top; expects clk and rst_n in scope.
`ifndef UNORDERED_TUPLE_HASH_TOP_MACROS_SVH
`define UNORDERED_TUPLE_HASH_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define UTH_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define UTH_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define UTH_ASSERT_IMP(lbl, ante, cons, msg)
`define UTH_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

### hdl/uth_pkg.sv
// Package for the unordered tuple hash block: sizes, constants, word types.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package uth_pkg;

    localparam int ELEM_FIELDS = 4;
    localparam int ELEM_W      = 32;
    localparam int TUPLE_SIZE  = 4;
    localparam int IDX_W       = (TUPLE_SIZE > 1) ? $clog2(TUPLE_SIZE) : 1;
    localparam int TERM_W      = ELEM_W + 1;
    localparam int HASH_W      = 64;
    localparam int IN_TDATA_W  = ((ELEM_FIELDS * ELEM_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((HASH_W + 7) / 8) * 8;
    localparam int MIX_LEFT    = 6;
    localparam int MIX_RIGHT   = 2;

    localparam logic [ELEM_W-1:0] GOLDEN_ADD = 32'h9e37_79b9;

    typedef logic [TUPLE_SIZE-1:0][ELEM_W-1:0] elem_vec_t;
    typedef logic [TUPLE_SIZE-1:0][IDX_W-1:0]  rank_vec_t;
    typedef logic [TUPLE_SIZE-1:0][TERM_W-1:0] term_vec_t;

    typedef struct packed {
        logic [HASH_W-1:0] h;
        term_vec_t         terms;
    } fold_word_t;

endpackage

### hdl/uth_rank_lane.sv
// One sorting lane: rank of its own element among all tuple elements.
// Ties broken by position so ranks form a permutation. Depends on uth_pkg.
`timescale 1ns / 1ps

module uth_rank_lane (
    input  uth_pkg::elem_vec_t              elems,
    input  logic [uth_pkg::IDX_W-1:0]       lane_idx,
    output logic [uth_pkg::IDX_W-1:0]       rank
);
    import uth_pkg::*;

    logic [ELEM_W-1:0] self_val;
    logic [IDX_W-1:0]  cnt;

    assign self_val = elems[lane_idx];

    always_comb
    begin
        cnt = '0;
        for (int j = 0; j < TUPLE_SIZE; j++)
        begin
            if (IDX_W'(j) != lane_idx)
            begin
                if ((elems[j] < self_val) ||
                    ((elems[j] == self_val) && (IDX_W'(j) < lane_idx)))
                begin
                    cnt = cnt + 1'b1;
                end
            end
        end
    end

    assign rank = cnt;

endmodule

### hdl/uth_fold_stage.sv
// One hash fold step as a registered pipeline stage with valid/ready.
// h ^= term + (h << 6) + (h >> 2). Depends on uth_pkg.
`timescale 1ns / 1ps

module uth_fold_stage (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [uth_pkg::IDX_W-1:0]   step_idx,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  uth_pkg::fold_word_t         in_word,
    output logic                        out_valid,
    input  logic                        out_ready,
    output uth_pkg::fold_word_t         out_word
);
    import uth_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    fold_word_t        word_reg;
    fold_word_t        word_next;
    logic [HASH_W-1:0] term;
    logic [HASH_W-1:0] mix_sum;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        term            = HASH_W'(in_word.terms[step_idx]);
        mix_sum         = term + (in_word.h << MIX_LEFT) + (in_word.h >> MIX_RIGHT);
        word_next       = in_word;
        word_next.h     = in_word.h ^ mix_sum;
        valid_next      = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

### hdl/unordered_tuple_hash_top.sv
// Top level of the unordered tuple hash block: rank lanes, merge, fold chain.
// Depends on uth_pkg, uth_rank_lane, uth_fold_stage and the macros header.
`timescale 1ns / 1ps

// Order-independent 64-bit key of four 32-bit elements. Takes one word per
// cycle while the output is not stalled and returns one word per input, in
// order. The lanes rank every element in parallel into the rank register,
// the registered merge stage places the elements in ascending order and
// adds the golden constant, then one registered fold stage per element.
// Every stage has its own valid/ready, so back-pressure on the output only
// stalls what is actually blocked and bubbles close up. No state survives
// between words; reset only clears the pipeline valid flags.

module unordered_tuple_hash_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // elem_0 [31:0], elem_1 [63:32], elem_2 [95:64], elem_3 [127:96]
    input  logic [uth_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // hash_key [63:0]
    output logic [uth_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import uth_pkg::*;

    `include "unordered_tuple_hash_top_macros.svh"

    elem_vec_t  elem_in;
    rank_vec_t  rank_in;

    logic       lane_valid_reg;
    logic       lane_valid_next;
    elem_vec_t  lane_elems_reg;
    rank_vec_t  lane_rank_reg;

    logic       scat_valid_reg;
    logic       scat_valid_next;
    logic       scat_ready;
    fold_word_t scat_word_reg;
    fold_word_t scat_word_next;
    logic [ELEM_W-1:0] picked;

    logic       fold_valid [TUPLE_SIZE+1];
    logic       fold_ready [TUPLE_SIZE+1];
    fold_word_t fold_word  [TUPLE_SIZE+1];

    logic [TUPLE_SIZE-1:0] rank_cover;
    logic                  terms_ordered;

    // unpack; positions past the field count read as zero
    for (genvar i = 0; i < TUPLE_SIZE; i++)
    begin : g_unpack
        if (i < ELEM_FIELDS)
        begin : g_field
            assign elem_in[i] = s_axis_tdata[i*ELEM_W +: ELEM_W];
        end
        else
        begin : g_zero
            assign elem_in[i] = '0;
        end
    end

    for (genvar i = 0; i < TUPLE_SIZE; i++)
    begin : g_lane
        uth_rank_lane u_lane (
            .elems    (elem_in),
            .lane_idx (IDX_W'(i)),
            .rank     (rank_in[i])
        );
    end

    // rank stage
    assign s_axis_tready   = !lane_valid_reg || scat_ready;
    assign lane_valid_next = s_axis_tready ? s_axis_tvalid : lane_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_valid_reg <= 1'b0;
        end
        else
        begin
            lane_valid_reg <= lane_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            lane_elems_reg <= elem_in;
            lane_rank_reg  <= rank_in;
        end
    end

    // merge stage: scatter by rank, pre-add golden constant
    assign scat_ready      = !scat_valid_reg || fold_ready[0];
    assign scat_valid_next = scat_ready ? lane_valid_reg : scat_valid_reg;

    always_comb
    begin
        scat_word_next   = '0;
        picked           = '0;
        for (int k = 0; k < TUPLE_SIZE; k++)
        begin
            picked = '0;
            for (int i = 0; i < TUPLE_SIZE; i++)
            begin
                if (lane_rank_reg[i] == IDX_W'(k))
                begin
                    picked = picked | lane_elems_reg[i];
                end
            end
            scat_word_next.terms[k] = {1'b0, picked} + {1'b0, GOLDEN_ADD};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scat_valid_reg <= 1'b0;
        end
        else
        begin
            scat_valid_reg <= scat_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scat_ready && lane_valid_reg)
        begin
            scat_word_reg <= scat_word_next;
        end
    end

    // fold chain
    assign fold_valid[0]          = scat_valid_reg;
    assign fold_word[0]           = scat_word_reg;
    assign fold_ready[TUPLE_SIZE] = m_axis_tready;

    for (genvar k = 0; k < TUPLE_SIZE; k++)
    begin : g_fold
        uth_fold_stage u_fold (
            .clk       (clk),
            .rst_n     (rst_n),
            .step_idx  (IDX_W'(k)),
            .in_valid  (fold_valid[k]),
            .in_ready  (fold_ready[k]),
            .in_word   (fold_word[k]),
            .out_valid (fold_valid[k+1]),
            .out_ready (fold_ready[k+1]),
            .out_word  (fold_word[k+1])
        );
    end

    assign m_axis_tvalid = fold_valid[TUPLE_SIZE];
    assign m_axis_tdata  = OUT_TDATA_W'(fold_word[TUPLE_SIZE].h);

    // checks
    always_comb
    begin
        rank_cover    = '0;
        terms_ordered = 1'b1;
        for (int k = 0; k < TUPLE_SIZE; k++)
        begin
            for (int i = 0; i < TUPLE_SIZE; i++)
            begin
                if (lane_rank_reg[i] == IDX_W'(k))
                begin
                    rank_cover[k] = 1'b1;
                end
            end
        end
        for (int k = 1; k < TUPLE_SIZE; k++)
        begin
            if (scat_word_reg.terms[k] < scat_word_reg.terms[k-1])
            begin
                terms_ordered = 1'b0;
            end
        end
    end

    `UTH_ASSERT_IMP(a_rank_perm, lane_valid_reg, &rank_cover, "lane ranks not a permutation")
    `UTH_ASSERT_IMP(a_sorted, scat_valid_reg, terms_ordered, "merged terms not ascending")
    `UTH_ASSERT_NXT(a_accept_lands, s_axis_tvalid && s_axis_tready, lane_valid_reg, "word lost")
    `UTH_ASSERT_IMP(a_ready_empty, !lane_valid_reg, s_axis_tready, "stalled with empty rank stage")

endmodule
